// ===== hdl/ratc_pkg.sv =====
package ratc_pkg;

  localparam int unsigned IndexBitsDef = 16;
  localparam int unsigned SetBitsDef   = 16;

  localparam int unsigned KindW = 3;
  localparam int unsigned CharW = 21;
  localparam int unsigned SetW  = 16;
  localparam int unsigned CmdW  = 16;
  localparam int unsigned ErrW  = 3;

  // Lexeme kinds.
  localparam logic [KindW-1:0] TokOpen   = 3'd0;
  localparam logic [KindW-1:0] TokClose  = 3'd1;
  localparam logic [KindW-1:0] TokOr     = 3'd2;
  localparam logic [KindW-1:0] TokChar   = 3'd3;
  localparam logic [KindW-1:0] TokClass  = 3'd4;
  localparam logic [KindW-1:0] TokCompl  = 3'd5;
  localparam logic [KindW-1:0] TokEnd    = 3'd6;
  localparam logic [KindW-1:0] TokUnused = 3'd7;

  // Result item kinds.
  localparam logic [KindW-1:0] ItemErr   = 3'd0;
  localparam logic [KindW-1:0] ItemChar  = 3'd1;
  localparam logic [KindW-1:0] ItemClass = 3'd2;
  localparam logic [KindW-1:0] ItemCompl = 3'd3;
  localparam logic [KindW-1:0] ItemMulti = 3'd4;
  localparam logic [KindW-1:0] ItemOr    = 3'd5;

  // Error codes.
  localparam logic [ErrW-1:0] ErrNone       = 3'd0;
  localparam logic [ErrW-1:0] ErrNoOpen     = 3'd1;
  localparam logic [ErrW-1:0] ErrExpElem    = 3'd2;
  localparam logic [ErrW-1:0] ErrExpElemCls = 3'd3;
  localparam logic [ErrW-1:0] ErrCompl      = 3'd4;
  localparam logic [ErrW-1:0] ErrEnd        = 3'd5;

  typedef struct packed {
    logic [KindW-1:0] token_kind;
    logic [CharW-1:0] char_code;
    logic [SetW-1:0]  class_index;
  } ratc_in_t;

  typedef struct packed {
    logic [KindW-1:0] item_kind;
    logic [CmdW-1:0]  command_index;
    logic [CharW-1:0] char_out;
    logic [SetW-1:0]  set_out;
    logic [CmdW-1:0]  first_arg;
    logic [CmdW-1:0]  second_arg;
    logic [ErrW-1:0]  error_code;
    logic             expr_done;
    logic             last_item;
  } ratc_out_t;

endpackage

// ===== hdl/regex_alternation_token_compiler_core.sv =====
// A lexeme is registered in the input register at its transfer; its results are written into the
// result buffer once that buffer is free, and the single result port delivers one result per
// cycle while out_stall_i is low, from a three-entry result buffer.
// The next lexeme is taken into the input register while earlier results are still delivered.
// Reset clears the parse state, the command counter and all valid flags at once;
// there is no clearing pass.
module regex_alternation_token_compiler_core
  import ratc_pkg::*;
#(
  parameter int unsigned INDEX_BITS = IndexBitsDef,
  parameter int unsigned SET_BITS   = SetBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ratc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ratc_out_t out_data_o
);

  localparam logic [SetW-1:0] SetMask =
      (SET_BITS >= SetW) ? {SetW{1'b1}} : SetW'((64'd1 << SET_BITS) - 64'd1);

  typedef enum logic [1:0] {
    PsBeginExpr   = 2'd0,
    PsBeginConcat = 2'd1,
    PsConcat      = 2'd2
  } ps_e;

  typedef logic [INDEX_BITS-1:0] idx_t;

  // Input register.
  logic     tok_valid_q, tok_valid_d;
  ratc_in_t tok_q;

  // Result buffer.
  ratc_out_t  slot_q [3];
  ratc_out_t  slot_d [3];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] rd_q, rd_d;

  // Parse state.
  ps_e        ps_q, ps_d;
  idx_t       ni_q, ni_d;
  idx_t       rs_q, rs_d;
  logic [1:0] rl_q, rl_d;
  logic       os_q, os_d;
  idx_t       lo_q, lo_d;

  logic accept, out_take, buf_free, process;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign buf_free    = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_take);
  assign process     = tok_valid_q && buf_free;
  assign in_stall_o  = tok_valid_q && !buf_free;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    case (rd_q)
      2'd1:    out_data_o = slot_q[1];
      2'd2:    out_data_o = slot_q[2];
      default: out_data_o = slot_q[0];
    endcase
  end

  // Per-lexeme decode: which results this lexeme produces and the next parse state.
  logic            elem, done, start;
  logic            e1_en, c_en, cm_en, cr_en, mc_en, or_en;
  logic [ErrW-1:0] e1_code;
  idx_t            ni_b, last_idx;
  ratc_out_t       cand [5];
  logic [4:0]      cand_en;
  ratc_out_t       new_slot [3];
  logic [2:0]      n_new;

  always_comb begin
    elem    = (tok_q.token_kind inside {TokChar, TokClass, TokCompl});
    done    = 1'b0;
    start   = 1'b0;
    e1_en   = 1'b0;
    e1_code = ErrNone;
    c_en    = 1'b0;
    cr_en   = 1'b0;
    ps_d    = ps_q;
    rs_d    = rs_q;
    rl_d    = rl_q;
    os_d    = os_q;
    lo_d    = lo_q;

    if (tok_q.token_kind == TokUnused) begin
      // Ignored lexeme: no results, no state change.
    end else if (tok_q.token_kind == TokEnd) begin
      e1_en   = 1'b1;
      e1_code = ErrEnd;
      cr_en   = (ps_q == PsBeginConcat) || (ps_q == PsConcat);
      done    = 1'b1;
    end else begin
      case (ps_q)
        PsBeginConcat: begin
          if (elem) begin
            c_en  = 1'b1;
            start = 1'b1;
          end else begin
            e1_en   = 1'b1;
            e1_code = ErrExpElem;
            done    = (tok_q.token_kind == TokClose);
          end
        end
        PsConcat: begin
          if (elem) begin
            c_en = 1'b1;
            rl_d = rl_q[1] ? 2'd2 : rl_q + 2'd1;
          end else if (tok_q.token_kind == TokOr) begin
            cr_en = 1'b1;
            rl_d  = 2'd0;
            ps_d  = PsBeginConcat;
          end else if (tok_q.token_kind == TokClose) begin
            cr_en = 1'b1;
            done  = 1'b1;
          end else begin
            e1_en   = 1'b1;
            e1_code = ErrExpElemCls;
          end
        end
        default: begin
          ps_d = PsBeginConcat;
          if (tok_q.token_kind != TokOpen) begin
            e1_en   = 1'b1;
            e1_code = ErrNoOpen;
            // An element without an open brace is taken again as the first element.
            if (elem) begin
              c_en  = 1'b1;
              start = 1'b1;
            end else begin
              done = (tok_q.token_kind == TokClose);
            end
          end
        end
      endcase
    end

    cm_en = c_en && (tok_q.token_kind == TokCompl);
    mc_en = cr_en && rl_q[1];
    or_en = cr_en && os_q;

    ni_b     = ni_q + idx_t'(mc_en);
    last_idx = ni_b - idx_t'(1);
    ni_d     = ni_b + idx_t'(or_en) + idx_t'(c_en);

    if (start) begin
      rs_d = ni_q;
      rl_d = 2'd1;
      ps_d = PsConcat;
    end

    if (cr_en) begin
      if (!os_q) begin
        os_d = 1'b1;
        lo_d = last_idx;
      end else begin
        lo_d = ni_b;
      end
    end

    if (done) begin
      ps_d = PsBeginExpr;
      rs_d = '0;
      rl_d = 2'd0;
      os_d = 1'b0;
      lo_d = '0;
    end

    // Candidate results in their order of emission.
    for (int i = 0; i < 5; i++) begin
      cand[i] = '0;
    end
    cand[0].item_kind  = ItemErr;
    cand[0].error_code = e1_code;
    cand[1].item_kind  = ItemErr;
    cand[1].error_code = ErrCompl;
    cand[2].command_index = CmdW'(ni_q);
    if (tok_q.token_kind == TokChar) begin
      cand[2].item_kind = ItemChar;
      cand[2].char_out  = tok_q.char_code;
    end else begin
      cand[2].item_kind = (tok_q.token_kind == TokClass) ? ItemClass : ItemCompl;
      cand[2].set_out   = tok_q.class_index & SetMask;
    end
    cand[3].item_kind     = ItemMulti;
    cand[3].command_index = CmdW'(ni_q);
    cand[3].first_arg     = CmdW'(rs_q);
    cand[3].second_arg    = CmdW'(ni_q - idx_t'(1));
    cand[4].item_kind     = ItemOr;
    cand[4].command_index = CmdW'(ni_b);
    cand[4].first_arg     = CmdW'(lo_q);
    cand[4].second_arg    = CmdW'(last_idx);
    cand_en = {or_en, mc_en, c_en, cm_en, e1_en};
  end

  // Pack the enabled candidates into the buffer entries and flag the last one.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      new_slot[j] = '0;
    end
    n_new = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (cand_en[i]) begin
        if (n_new < 3'd3) begin
          new_slot[n_new[1:0]] = cand[i];
        end
        n_new = n_new + 3'd1;
      end
    end
    for (int j = 0; j < 3; j++) begin
      new_slot[j].last_item = (n_new == 3'(j + 1));
      new_slot[j].expr_done = done && (n_new == 3'(j + 1));
    end
  end

  always_comb begin
    tok_valid_d = tok_valid_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    for (int j = 0; j < 3; j++) begin
      slot_d[j] = slot_q[j];
    end
    if (process) begin
      tok_valid_d = 1'b0;
      cnt_d       = n_new[1:0];
      rd_d        = 2'd0;
      for (int j = 0; j < 3; j++) begin
        slot_d[j] = new_slot[j];
      end
    end else if (out_take) begin
      cnt_d = cnt_q - 2'd1;
      rd_d  = rd_q + 2'd1;
    end
    if (accept) begin
      tok_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
      tok_q       <= '0;
      cnt_q       <= 2'd0;
      rd_q        <= 2'd0;
      for (int j = 0; j < 3; j++) begin
        slot_q[j] <= '0;
      end
      ps_q        <= PsBeginExpr;
      ni_q        <= '0;
      rs_q        <= '0;
      rl_q        <= 2'd0;
      os_q        <= 1'b0;
      lo_q        <= '0;
    end else begin
      tok_valid_q <= tok_valid_d;
      if (accept) begin
        tok_q <= in_data_i;
      end
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      for (int j = 0; j < 3; j++) begin
        slot_q[j] <= slot_d[j];
      end
      if (process) begin
        ps_q <= ps_d;
        ni_q <= ni_d;
        rs_q <= rs_d;
        rl_q <= rl_d;
        os_q <= os_d;
        lo_q <= lo_d;
      end
    end
  end

  // The read pointer and the remaining count never run past the three entries.
  a_buf_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} + {1'b0, rd_q}) <= 3'd3)
    else $error("result buffer pointer overrun");

  // An error report carries a code and no command index.
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.item_kind == ItemErr)) |->
      ((out_data_o.error_code != ErrNone) && (out_data_o.command_index == '0)))
    else $error("malformed error report");

  // A transfer that is not the last of its lexeme leaves more results behind.
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !out_data_o.last_item) |=> (cnt_q != 2'd0))
    else $error("result sequence cut short");

  // The last result of a lexeme empties the buffer unless a new lexeme is loaded.
  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && out_data_o.last_item && !tok_valid_q) |=> (cnt_q == 2'd0))
    else $error("results left after the last item");

  // A stalled input always has a lexeme waiting in the input register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (tok_valid_q && (cnt_q != 2'd0)))
    else $error("input stalled without a pending lexeme");

endmodule

// ===== tb/ratc_checker.sv =====
`timescale 1ns / 100ps

module ratc_checker
  import ratc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  ratc_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  ratc_out_t out_data_i,
  output int        errors_o,
  output int        pending_o
);

  localparam logic [1:0] PsBeginExpr   = 2'd0;
  localparam logic [1:0] PsBeginConcat = 2'd1;
  localparam logic [1:0] PsConcat      = 2'd2;

  localparam int MaxReports = 40;

  // Parse state of the compiler as this checker tracks it.
  logic [1:0]      parse_st;
  logic [CmdW-1:0] next_cmd;
  logic [CmdW-1:0] run_first;
  logic [1:0]      run_len;
  logic            alt_seen;
  logic [CmdW-1:0] alt_left;

  ratc_out_t lexeme_results[$];
  ratc_out_t expected_results[$];
  ratc_out_t want;
  int        mismatches;
  int        reports;
  logic      bad;

  task automatic add_result(input logic [KindW-1:0] kind, input logic [CmdW-1:0] idx,
                            input logic [CharW-1:0] ch, input logic [SetW-1:0] setv,
                            input logic [CmdW-1:0] a1, input logic [CmdW-1:0] a2,
                            input logic [ErrW-1:0] err);
    ratc_out_t r;
    r = '0;
    r.item_kind     = kind;
    r.command_index = idx;
    r.char_out      = ch;
    r.set_out       = setv;
    r.first_arg     = a1;
    r.second_arg    = a2;
    r.error_code    = err;
    lexeme_results.insert(lexeme_results.size(), r);
  endtask

  task automatic add_error(input logic [ErrW-1:0] err);
    add_result(ItemErr, '0, '0, '0, '0, '0, err);
  endtask

  task automatic take_cmd(output logic [CmdW-1:0] idx);
    idx = next_cmd;
    next_cmd = next_cmd + 1'b1;
  endtask

  task automatic emit_element(input ratc_in_t tok, output logic [CmdW-1:0] idx);
    if (tok.token_kind == TokCompl) add_error(ErrCompl);
    take_cmd(idx);
    if (tok.token_kind == TokChar) begin
      add_result(ItemChar, idx, tok.char_code, '0, '0, '0, ErrNone);
    end else if (tok.token_kind == TokClass) begin
      add_result(ItemClass, idx, '0, tok.class_index, '0, '0, ErrNone);
    end else begin
      add_result(ItemCompl, idx, '0, tok.class_index, '0, '0, ErrNone);
    end
  endtask

  // Ends the current run: a multiconcat spans it if it holds more than one
  // element, and from the second alternative on an Or joins it to the left side.
  task automatic close_run();
    logic [CmdW-1:0] last;
    logic [CmdW-1:0] idx;
    if (run_len > 2'd1) begin
      last = next_cmd - 1'b1;
      take_cmd(idx);
      add_result(ItemMulti, idx, '0, '0, run_first, last, ErrNone);
    end
    last = next_cmd - 1'b1;
    if (!alt_seen) begin
      alt_seen = 1'b1;
      alt_left = last;
    end else begin
      take_cmd(idx);
      add_result(ItemOr, idx, '0, '0, alt_left, last, ErrNone);
      alt_left = idx;
    end
  endtask

  task automatic predict_lexeme(input ratc_in_t tok);
    logic [KindW-1:0] kind;
    logic             is_elem;
    logic             finished;
    logic             again;
    logic [CmdW-1:0]  idx;
    ratc_out_t        tail;
    kind = tok.token_kind;
    is_elem = kind inside {TokChar, TokClass, TokCompl};
    finished = 1'b0;
    lexeme_results.delete();
    if (kind == TokUnused) return;
    if (kind == TokEnd) begin
      add_error(ErrEnd);
      if (parse_st == PsBeginConcat || parse_st == PsConcat) close_run();
      finished = 1'b1;
    end else begin
      do begin
        again = 1'b0;
        case (parse_st)
          PsBeginConcat: begin
            if (is_elem) begin
              emit_element(tok, idx);
              run_first = idx;
              run_len = 2'd1;
              parse_st = PsConcat;
            end else begin
              add_error(ErrExpElem);
              if (kind == TokClose) finished = 1'b1;
            end
          end
          PsConcat: begin
            if (is_elem) begin
              emit_element(tok, idx);
              if (run_len < 2'd2) run_len = run_len + 1'b1;
            end else if (kind == TokOr) begin
              close_run();
              run_len = 2'd0;
              parse_st = PsBeginConcat;
            end else if (kind == TokClose) begin
              close_run();
              finished = 1'b1;
            end else begin
              add_error(ErrExpElemCls);
            end
          end
          default: begin
            // Begin expression, and the unused state code behaves the same.
            parse_st = PsBeginConcat;
            if (kind != TokOpen) begin
              add_error(ErrNoOpen);
              if (is_elem) again = 1'b1;
              else if (kind == TokClose) finished = 1'b1;
            end
          end
        endcase
      end while (again);
    end
    if (finished) begin
      parse_st  = PsBeginExpr;
      run_first = '0;
      run_len   = 2'd0;
      alt_seen  = 1'b0;
      alt_left  = '0;
    end
    if (lexeme_results.size() > 0) begin
      tail = lexeme_results[lexeme_results.size()-1];
      tail.last_item = 1'b1;
      if (finished) tail.expr_done = 1'b1;
      lexeme_results[lexeme_results.size()-1] = tail;
    end
    foreach (lexeme_results[i]) begin
      expected_results.insert(expected_results.size(), lexeme_results[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v, inout logic any_bad);
    if (want_v !== got_v) begin
      any_bad = 1'b1;
      if (reports < MaxReports) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
        reports++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_st   = PsBeginExpr;
      next_cmd   = '0;
      run_first  = '0;
      run_len    = 2'd0;
      alt_seen   = 1'b0;
      alt_left   = '0;
      mismatches = 0;
      reports    = 0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) predict_lexeme(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (reports < MaxReports) begin
            $display("%0t: result expected none actual %0h", $time, out_data_i);
            reports++;
          end
        end else begin
          want = expected_results.pop_front();
          bad = 1'b0;
          check_field("item_kind", 32'(want.item_kind), 32'(out_data_i.item_kind), bad);
          check_field("command_index", 32'(want.command_index),
                      32'(out_data_i.command_index), bad);
          check_field("char_out", 32'(want.char_out), 32'(out_data_i.char_out), bad);
          check_field("set_out", 32'(want.set_out), 32'(out_data_i.set_out), bad);
          check_field("first_arg", 32'(want.first_arg), 32'(out_data_i.first_arg), bad);
          check_field("second_arg", 32'(want.second_arg), 32'(out_data_i.second_arg), bad);
          check_field("error_code", 32'(want.error_code), 32'(out_data_i.error_code), bad);
          check_field("expr_done", 32'(want.expr_done), 32'(out_data_i.expr_done), bad);
          check_field("last_item", 32'(want.last_item), 32'(out_data_i.last_item), bad);
          if (bad) mismatches++;
        end
      end
    end
    errors_o  <= mismatches;
    pending_o <= expected_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench
  import ratc_pkg::*;
();

  localparam int LexemeCount = 310;
  localparam int CalmFrom    = 250;
  localparam int HoldAt      = 60;
  localparam int HoldCycles  = 100;
  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 12;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  ratc_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  ratc_out_t out_data;

  int   errors;
  int   pending;
  int   sent_count;
  int   quiet_cycles;
  logic idle_on;
  logic held;

  regex_alternation_token_compiler_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  ratc_checker scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    idle_on    = 1'b1;
    held       = 1'b0;
    sent_count = 0;
  end

  always #10 clk_i = ~clk_i;

  function automatic ratc_in_t lexeme(input logic [KindW-1:0] kind,
                                      input logic [CharW-1:0] ch,
                                      input logic [SetW-1:0] cls);
    ratc_in_t t;
    t.token_kind  = kind;
    t.char_code   = ch;
    t.class_index = cls;
    return t;
  endfunction

  function automatic ratc_in_t random_lexeme(input logic [KindW-1:0] kind);
    return lexeme(kind, CharW'($urandom_range(0, 21'h10FFFF)),
                  SetW'($urandom_range(0, 16'hFFFF)));
  endfunction

  function automatic ratc_in_t random_element();
    logic [KindW-1:0] kind;
    case ($urandom_range(0, 2))
      0:       kind = TokChar;
      1:       kind = TokClass;
      default: kind = TokCompl;
    endcase
    return random_lexeme(kind);
  endfunction

  // Called at a rising edge; returns at the edge where the lexeme transfers.
  task automatic send_lexeme(input ratc_in_t tok);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= tok;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (tok.token_kind != TokUnused) sent_count++;
  endtask

  // Mostly well-formed expressions; some lack the open brace, some have an
  // empty alternative, a stray token or no terminator at all.
  task automatic send_expression();
    int alts;
    int elems;
    int ending;
    if ($urandom_range(0, 9) != 0) send_lexeme(random_lexeme(TokOpen));
    alts = $urandom_range(1, 4);
    for (int a = 0; a < alts; a++) begin
      if (a > 0) send_lexeme(random_lexeme(TokOr));
      elems = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
      for (int e = 0; e < elems; e++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_lexeme(random_lexeme(KindW'($urandom_range(0, 7))));
        end
        send_lexeme(random_element());
      end
    end
    ending = $urandom_range(0, 9);
    if (ending < 8) send_lexeme(random_lexeme(TokClose));
    else if (ending == 8) send_lexeme(random_lexeme(TokEnd));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_lexeme(lexeme(TokUnused, 21'h1FFFFF, 16'hFFFF));
    send_lexeme(lexeme(TokClose, '0, '0));
    send_lexeme(lexeme(TokChar, '0, 16'hFFFF));
    send_lexeme(lexeme(TokClass, 21'h10FFFF, 16'hFFFF));
    send_lexeme(lexeme(TokCompl, '0, '0));
    send_lexeme(lexeme(TokClose, '0, '0));
    send_lexeme(lexeme(TokEnd, '0, '0));
    send_lexeme(lexeme(TokOpen, '0, '0));
    send_lexeme(lexeme(TokOpen, 21'h10FFFF, 16'hFFFF));
    send_lexeme(lexeme(TokChar, 21'h10FFFF, '0));
    send_lexeme(lexeme(TokOr, '0, '0));
    send_lexeme(lexeme(TokOr, '0, '0));
    send_lexeme(lexeme(TokCompl, '0, 16'hFFFF));
    send_lexeme(lexeme(TokOr, '0, '0));
    send_lexeme(lexeme(TokClass, '0, 16'h0000));
    send_lexeme(lexeme(TokChar, 21'h000001, '0));
    send_lexeme(lexeme(TokOpen, '0, '0));
    send_lexeme(lexeme(TokEnd, '0, '0));
    send_lexeme(lexeme(TokOpen, '0, '0));
    send_lexeme(lexeme(TokClose, '0, '0));
    send_lexeme(lexeme(TokOpen, '0, '0));
    send_lexeme(lexeme(TokChar, 21'h00005A, '0));
    send_lexeme(lexeme(TokUnused, '0, '0));
    send_lexeme(lexeme(TokClose, '0, '0));
    send_lexeme(lexeme(TokOpen, '0, '0));
    send_lexeme(lexeme(TokEnd, '0, '0));

    while (sent_count < LexemeCount) begin
      if (sent_count >= CalmFrom) idle_on = 1'b0;
      if ($urandom_range(0, 6) == 0) send_lexeme(random_lexeme(KindW'($urandom_range(0, 7))));
      else send_expression();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("regex_alternation_token_compiler_core verification clean");
    end else begin
      $display("regex_alternation_token_compiler_core verification failed");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off that lets the
  // block fill up while the sender keeps offering lexemes.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && sent_count >= HoldAt) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("regex_alternation_token_compiler_core verification failed");
        $finish;
      end
    end
  end

endmodule
